// ----- rtl/core/nbu_pkg.sv -----
package nbu_pkg;

  localparam int MAX_INPUTS    = 256;
  localparam int ADDR_BITS     = $clog2(MAX_INPUTS);
  localparam int VALUE_BITS    = 16;
  localparam int FRACTION_BITS = 12;
  localparam int ACC_BITS      = 40;
  localparam int WIDE_BITS     = 48;
  localparam int MUL_BITS      = 18;
  localparam int PROD_BITS     = 2 * MUL_BITS;
  localparam int COEF_BITS     = 16;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_FORWARD = 3'd1;
  localparam logic [2:0] OP_OUT_GRD = 3'd2;
  localparam logic [2:0] OP_HID_GRD = 3'd3;
  localparam logic [2:0] OP_UPDATE  = 3'd4;

  localparam logic [1:0] KIND_OUTPUT = 2'd0;
  localparam logic [1:0] KIND_GRAD   = 2'd1;
  localparam logic [1:0] KIND_WEIGHT = 2'd2;

  localparam logic CFG_LEARNING_RATE = 1'b0;
  localparam logic CFG_MOMENTUM      = 1'b1;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         index;
    logic signed [15:0] value;
    logic signed [15:0] partner_weight;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] result_value;
    logic [7:0]         result_index;
  } out_item_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_BITS-1:0]  addr;
    logic [VALUE_BITS-1:0] weight;
    logic [VALUE_BITS-1:0] delta;
  } store_wr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MAC_MUL, S_MAC_ACC, S_TANH_ABS, S_TANH_MUL, S_TANH_OUT,
    S_HID_DOW, S_SQ_MUL, S_SQ_DER, S_GRD_MUL, S_GRD_OUT,
    S_UPD_XG_MUL, S_UPD_XG, S_UPD_T1_MUL, S_UPD_T1, S_UPD_T2_MUL, S_UPD_OUT,
    S_EMIT
  } state_t;

  // round half away from zero
  function automatic logic signed [WIDE_BITS-1:0] rnd_shift(
      input logic signed [WIDE_BITS-1:0] p, input int s);
    logic [WIDE_BITS-1:0] m;
    m = p[WIDE_BITS-1] ? WIDE_BITS'(-p) : p;
    m = (m + (WIDE_BITS'(1) << (s - 1))) >> s;
    return p[WIDE_BITS-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] sat_val(
      input logic signed [WIDE_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    hi = (WIDE_BITS'(1) <<< (VALUE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[VALUE_BITS-1:0];
    if (v < lo) return lo[VALUE_BITS-1:0];
    return v[VALUE_BITS-1:0];
  endfunction

  // tanh at steps of 1/4 in Q.12
  function automatic logic [12:0] tanh_tbl(input logic [5:0] i);
    logic [12:0] y;
    case (i)
      6'd0:  y = 13'd0;    6'd1:  y = 13'd1003; 6'd2:  y = 13'd1893;
      6'd3:  y = 13'd2602; 6'd4:  y = 13'd3119; 6'd5:  y = 13'd3475;
      6'd6:  y = 13'd3707; 6'd7:  y = 13'd3856; 6'd8:  y = 13'd3949;
      6'd9:  y = 13'd4006; 6'd10: y = 13'd4041; 6'd11: y = 13'd4063;
      6'd12: y = 13'd4076; 6'd13: y = 13'd4084; 6'd14: y = 13'd4089;
      6'd15: y = 13'd4091; 6'd16: y = 13'd4093; 6'd17: y = 13'd4094;
      6'd18: y = 13'd4095; 6'd19: y = 13'd4095;
      default: y = 13'd4096;
    endcase
    return y;
  endfunction

endpackage

// ----- rtl/core/nbu_in_if.sv -----
interface nbu_in_if;
  logic               valid;
  logic               ready;
  nbu_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/nbu_out_if.sv -----
interface nbu_out_if;
  logic               valid;
  logic               ready;
  nbu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/nbu_store.sv -----
module nbu_store (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_en,
  input  logic [nbu_pkg::ADDR_BITS-1:0]        rd_addr,
  input  nbu_pkg::store_wr_t                   wr,
  output logic [nbu_pkg::VALUE_BITS-1:0]       rd_weight,
  output logic [nbu_pkg::VALUE_BITS-1:0]       rd_delta
);
  import nbu_pkg::*;

  logic [VALUE_BITS-1:0] wmem [MAX_INPUTS];
  logic [VALUE_BITS-1:0] dmem [MAX_INPUTS];
  logic [MAX_INPUTS-1:0] dvld_r;
  logic [VALUE_BITS-1:0] rd_weight_r;
  logic [VALUE_BITS-1:0] rd_delta_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      wmem[wr.addr] <= wr.weight;
      dmem[wr.addr] <= wr.delta;
    end
    if (rd_en) begin
      rd_weight_r <= wmem[rd_addr];
      rd_delta_r  <= dmem[rd_addr];
    end
  end

  // deltas read as zero until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) dvld_r[wr.addr] <= 1'b1;
      if (rd_en) rd_vld_r <= dvld_r[rd_addr];
    end
  end

  assign rd_weight = rd_weight_r;
  assign rd_delta  = rd_vld_r ? rd_delta_r : '0;

endmodule

// ----- rtl/core/neuron_backprop_unit_core.sv -----
// one request at a time; a weight load or unknown operation returns to idle, a
// forward element or a hidden element but the last multiplies and accumulates,
// the last forward element forms tanh, an output gradient or last hidden element
// the gradient, an update the new weight and delta, all on one shared multiplier;
// emit moves the result into the output register, waiting while output stalls;
// reset clears the accumulator, neuron output and gradient, the delta valid
// bits and the registers to eta 9830 and alpha 32768; weights are undefined
module neuron_backprop_unit_core (
  input  logic       clk,
  input  logic       rst_n,
  nbu_in_if.sink     in_ch,
  nbu_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [nbu_pkg::COEF_BITS-1:0] cfg_data
);
  import nbu_pkg::*;

  localparam int AW = ADDR_BITS;

  state_t state_r, state_nxt;

  logic [COEF_BITS-1:0]   lr_r, mom_r;
  logic [2:0]             op_r;
  logic [AW-1:0]          idx_r;
  logic signed [15:0]     val_r, partner_r;
  logic                   last_r;
  logic signed [ACC_BITS-1:0] acc_r;
  logic signed [15:0]     out_r, grad_r, dow_r, xg_r;
  logic signed [16:0]     deriv_r, t1_r;
  logic [ACC_BITS-1:0]    abs_r;
  logic                   neg_r, big_r;
  logic [12:0]            base_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic [1:0]             res_kind_r;
  logic signed [15:0]     res_val_r;
  logic [AW-1:0]          res_idx_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic signed [MUL_BITS-1:0] mul_a, mul_b;
  logic                   accept, rd_en, out_free;
  store_wr_t              wr;
  logic [VALUE_BITS-1:0]  rd_weight, rd_delta;

  logic signed [WIDE_BITS-1:0] prod_w;
  logic signed [ACC_BITS:0]    acc_sum;
  logic signed [ACC_BITS-1:0]  acc_sat;
  logic [27:0]                 tq;
  logic signed [15:0]          nd, new_w, tanh_y;
  logic signed [WIDE_BITS-1:0] t2_w;

  nbu_store u_store (
    .clk, .rst_n, .rd_en, .rd_addr(in_ch.data.index[AW-1:0]), .wr,
    .rd_weight, .rd_delta
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign prod_w   = WIDE_BITS'(prod_r);

  always_comb begin
    acc_sum = {acc_r[ACC_BITS-1], acc_r} + (ACC_BITS+1)'(prod_r);
    if (acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1])
      acc_sat = acc_sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                  : {1'b0, {(ACC_BITS-1){1'b1}}};
    else
      acc_sat = acc_sum[ACC_BITS-1:0];
  end

  assign tq = abs_r[ACC_BITS-1:FRACTION_BITS];

  always_comb begin
    logic [12:0] y;
    y = big_r ? 13'd4096 : base_r + 13'(prod_r[PROD_BITS-1:10]);
    tanh_y = neg_r ? -$signed({3'b000, y}) : $signed({3'b000, y});
  end

  assign t2_w  = rnd_shift(prod_w, 16);
  assign nd    = sat_val(WIDE_BITS'(t1_r) + t2_w);
  assign new_w = sat_val(WIDE_BITS'($signed(rd_weight)) + WIDE_BITS'(nd));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.data.operation)
            OP_FORWARD: state_nxt = S_MAC_MUL;
            OP_OUT_GRD: state_nxt = S_SQ_MUL;
            OP_HID_GRD: state_nxt = in_ch.data.last ? S_HID_DOW : S_MAC_MUL;
            OP_UPDATE:  state_nxt = S_UPD_XG_MUL;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_MAC_MUL:    state_nxt = S_MAC_ACC;
      S_MAC_ACC:    state_nxt = (op_r == OP_FORWARD && last_r) ? S_TANH_ABS : S_IDLE;
      S_TANH_ABS:   state_nxt = S_TANH_MUL;
      S_TANH_MUL:   state_nxt = S_TANH_OUT;
      S_TANH_OUT:   state_nxt = S_EMIT;
      S_HID_DOW:    state_nxt = S_SQ_MUL;
      S_SQ_MUL:     state_nxt = S_SQ_DER;
      S_SQ_DER:     state_nxt = S_GRD_MUL;
      S_GRD_MUL:    state_nxt = S_GRD_OUT;
      S_GRD_OUT:    state_nxt = S_EMIT;
      S_UPD_XG_MUL: state_nxt = S_UPD_XG;
      S_UPD_XG:     state_nxt = S_UPD_T1_MUL;
      S_UPD_T1_MUL: state_nxt = S_UPD_T1;
      S_UPD_T1:     state_nxt = S_UPD_T2_MUL;
      S_UPD_T2_MUL: state_nxt = S_UPD_OUT;
      S_UPD_OUT:    state_nxt = S_EMIT;
      S_EMIT:       state_nxt = out_free ? S_IDLE : S_EMIT;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, multiplier operands, store write
  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    wr          = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        rd_en       = in_ch.valid;
        if (accept && in_ch.data.operation == OP_LOAD) begin
          wr.en     = 1'b1;
          wr.addr   = in_ch.data.index[AW-1:0];
          wr.weight = in_ch.data.value;
          wr.delta  = '0;
        end
      end
      S_MAC_MUL: begin
        mul_a = MUL_BITS'(val_r);
        mul_b = (op_r == OP_FORWARD) ? MUL_BITS'($signed(rd_weight))
                                     : MUL_BITS'(partner_r);
      end
      S_TANH_MUL: begin
        mul_a = MUL_BITS'(tanh_tbl({1'b0, tq[14:10]} + 6'd1) - tanh_tbl({1'b0, tq[14:10]}));
        mul_b = MUL_BITS'(tq[9:0]);
      end
      S_SQ_MUL: begin
        mul_a = MUL_BITS'(out_r);
        mul_b = MUL_BITS'(out_r);
      end
      S_GRD_MUL: begin
        mul_a = (op_r == OP_OUT_GRD) ? MUL_BITS'(val_r) - MUL_BITS'(out_r)
                                     : MUL_BITS'(dow_r);
        mul_b = MUL_BITS'(deriv_r);
      end
      S_UPD_XG_MUL: begin
        mul_a = MUL_BITS'(val_r);
        mul_b = MUL_BITS'(grad_r);
      end
      S_UPD_T1_MUL: begin
        mul_a = MUL_BITS'(lr_r);
        mul_b = MUL_BITS'(xg_r);
      end
      S_UPD_T2_MUL: begin
        mul_a = MUL_BITS'(mom_r);
        mul_b = MUL_BITS'($signed(rd_delta));
      end
      S_UPD_OUT: begin
        wr.en     = 1'b1;
        wr.addr   = idx_r;
        wr.weight = new_w;
        wr.delta  = nd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (accept) begin
      op_r      <= in_ch.data.operation;
      idx_r     <= in_ch.data.index[AW-1:0];
      val_r     <= in_ch.data.value;
      partner_r <= in_ch.data.partner_weight;
      last_r    <= in_ch.data.last;
    end
    case (state_r)
      S_TANH_ABS: begin
        abs_r <= acc_r[ACC_BITS-1] ? ACC_BITS'(-acc_r) : acc_r;
        neg_r <= acc_r[ACC_BITS-1];
      end
      S_TANH_MUL: begin
        big_r  <= |tq[27:15];
        base_r <= tanh_tbl({1'b0, tq[14:10]});
      end
      S_HID_DOW: dow_r <= sat_val(rnd_shift(WIDE_BITS'(acc_r), FRACTION_BITS));
      S_SQ_DER: deriv_r <= 17'sd4096
                  - 17'(sat_val(rnd_shift(prod_w, FRACTION_BITS)));
      S_UPD_XG: xg_r <= sat_val(rnd_shift(prod_w, FRACTION_BITS));
      S_UPD_T1: t1_r <= 17'(rnd_shift(prod_w, 16));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lr_r        <= 16'd9830;
      mom_r       <= 16'd32768;
      acc_r       <= '0;
      out_r       <= '0;
      grad_r      <= '0;
      out_valid_r <= 1'b0;
      res_kind_r  <= KIND_OUTPUT;
      res_val_r   <= '0;
      res_idx_r   <= '0;
      out_data_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_LEARNING_RATE) lr_r <= cfg_data;
        else mom_r <= cfg_data;
      end
      if (state_r == S_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_MAC_ACC:  acc_r <= acc_sat;
        S_TANH_ABS: acc_r <= '0;
        S_HID_DOW:  acc_r <= '0;
        S_TANH_OUT: begin
          out_r      <= tanh_y;
          res_kind_r <= KIND_OUTPUT;
          res_val_r  <= tanh_y;
          res_idx_r  <= '0;
        end
        S_GRD_OUT: begin
          grad_r     <= sat_val(rnd_shift(prod_w, FRACTION_BITS));
          res_kind_r <= KIND_GRAD;
          res_val_r  <= sat_val(rnd_shift(prod_w, FRACTION_BITS));
          res_idx_r  <= '0;
        end
        S_UPD_OUT: begin
          res_kind_r <= KIND_WEIGHT;
          res_val_r  <= new_w;
          res_idx_r  <= idx_r;
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_r.kind         <= res_kind_r;
            out_data_r.result_value <= res_val_r;
            out_data_r.result_index <= 8'(res_idx_r);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import nbu_pkg::*;

  localparam int PHASE_ITEMS = 500;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } drow_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_LEARNING_RATE;
  logic [COEF_BITS-1:0] cfg_data = '0;

  nbu_in_if  in_bus ();
  nbu_out_if out_bus ();

  neuron_backprop_unit_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // neuron state mirror
  longint eta = 9830;
  longint alpha = 32768;
  longint weights [256];
  longint deltas [256];
  bit     loaded [256];
  longint acc_sum;
  longint neuron_out;
  longint neuron_grad;
  const longint tanh_pts [33] = '{
    0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949, 4006, 4041,
    4063, 4076, 4084, 4089, 4091, 4093, 4094, 4095, 4095, 4096,
    4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096};

  out_item_t pending_results [$];
  int        errors;
  int        idle_mode;
  longint    cycles;

  function automatic longint q_round(longint p, int s);
    longint m;
    m = (p < 0) ? -p : p;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint q_sat(longint v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic void acc_add(longint p);
    longint amax;
    amax = (longint'(1) <<< 39) - 1;
    acc_sum = acc_sum + p;
    if (acc_sum > amax) acc_sum = amax;
    if (acc_sum < -amax - 1) acc_sum = -amax - 1;
  endfunction

  function automatic longint tanh_of_sum(longint a);
    longint t, seg, frac, y;
    t = ((a < 0) ? -a : a) >>> FRACTION_BITS;
    seg = t >>> 10;
    if (seg >= 32) begin
      y = 4096;
    end else begin
      frac = t & 1023;
      y = tanh_pts[seg] + (((tanh_pts[seg + 1] - tanh_pts[seg]) * frac) >>> 10);
    end
    y = q_sat(y);
    return (a < 0) ? -y : y;
  endfunction

  function automatic longint tanh_slope();
    return 4096 - q_sat(q_round(neuron_out * neuron_out, FRACTION_BITS));
  endfunction

  // advances the mirror by one request, returns 1 when a result is due
  function automatic bit neuron_step(in_item_t it, output out_item_t res);
    longint v, pw, dow, xg, t1, t2, nd;
    int ix;
    v = longint'(it.value);
    pw = longint'(it.partner_weight);
    ix = it.index;
    res = '0;
    case (it.operation)
      OP_LOAD: begin
        weights[ix] = v;
        deltas[ix] = 0;
        loaded[ix] = 1'b1;
        return 1'b0;
      end
      OP_FORWARD: begin
        acc_add(v * weights[ix]);
        if (!it.last) return 1'b0;
        neuron_out = tanh_of_sum(acc_sum);
        acc_sum = 0;
        res.kind = KIND_OUTPUT;
        res.result_value = neuron_out[15:0];
      end
      OP_OUT_GRD: begin
        neuron_grad = q_sat(q_round((v - neuron_out) * tanh_slope(), FRACTION_BITS));
        res.kind = KIND_GRAD;
        res.result_value = neuron_grad[15:0];
      end
      OP_HID_GRD: begin
        if (!it.last) begin
          acc_add(v * pw);
          return 1'b0;
        end
        dow = q_sat(q_round(acc_sum, FRACTION_BITS));
        acc_sum = 0;
        neuron_grad = q_sat(q_round(dow * tanh_slope(), FRACTION_BITS));
        res.kind = KIND_GRAD;
        res.result_value = neuron_grad[15:0];
      end
      OP_UPDATE: begin
        xg = q_sat(q_round(v * neuron_grad, FRACTION_BITS));
        t1 = q_round(eta * xg, 16);
        t2 = q_round(alpha * deltas[ix], 16);
        nd = q_sat(t1 + t2);
        deltas[ix] = nd;
        weights[ix] = q_sat(weights[ix] + nd);
        res.kind = KIND_WEIGHT;
        res.result_value = weights[ix][15:0];
        res.result_index = it.index;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // extremes now and then, otherwise full-range or modest magnitudes
  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return $urandom();
      default: return 16'($signed($urandom_range(16384)) - 8192);
    endcase
  endfunction

  function automatic logic [7:0] pick_loaded();
    logic [7:0] ix;
    ix = $urandom();
    while (!loaded[ix]) ix = ix + 8'd1;
    return ix;
  endfunction

  always @(negedge clk) begin
    case (idle_mode)
      2: out_bus.ready <= !chance(87);
      3: out_bus.ready <= !chance(18);
      default: out_bus.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d value=%0d index=%0d", out_bus.data.kind,
               out_bus.data.result_value, out_bus.data.result_index);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_bus.data.kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, out_bus.data.kind);
          errors++;
        end
        if (out_bus.data.result_value !== exp_r.result_value) begin
          $error("result_value: expected %0d, got %0d", exp_r.result_value,
                 out_bus.data.result_value);
          errors++;
        end
        if (out_bus.data.result_index !== exp_r.result_index) begin
          $error("result_index: expected %0d, got %0d", exp_r.result_index,
                 out_bus.data.result_index);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t res;
    while ((idle_mode == 1 && chance(87)) || (idle_mode == 3 && chance(18))) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.data = it;
    in_bus.valid = 1'b1;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    if (neuron_step(it, res)) pending_results = {pending_results, typed ? want : res};
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_LEARNING_RATE) eta = val;
    else alpha = val;
  endtask

  task automatic mk(output in_item_t it, input logic [2:0] op, input logic [7:0] ix,
                    input logic [15:0] v, input logic [15:0] pw, input logic lst);
    it.operation = op;
    it.index = ix;
    it.value = v;
    it.partner_weight = pw;
    it.last = lst;
  endtask

  task automatic random_phase();
    in_item_t it;
    int sent, n;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if (chance(75)) begin
        n = $urandom_range(4);
        repeat (n) begin
          mk(it, OP_LOAD, $urandom(), pick_value(), $urandom(), $urandom());
          send(it);
        end
        sent += n;
        n = $urandom_range(1, 6);
        for (int k = 1; k <= n; k++) begin
          mk(it, OP_FORWARD, pick_loaded(), pick_value(), $urandom(), k == n);
          send(it);
        end
        sent += n;
        if (chance(50)) begin
          mk(it, OP_OUT_GRD, $urandom(), pick_value(), $urandom(), $urandom());
          send(it);
          sent++;
        end else begin
          n = $urandom_range(1, 5);
          for (int k = 1; k <= n; k++) begin
            mk(it, OP_HID_GRD, $urandom(), pick_value(), pick_value(), k == n);
            send(it);
          end
          sent += n;
        end
        n = $urandom_range(1, 4);
        repeat (n) begin
          mk(it, OP_UPDATE, pick_loaded(), pick_value(), $urandom(), $urandom());
          send(it);
        end
        sent += n;
      end else begin
        mk(it, 3'($urandom_range(7)), $urandom(), pick_value(), pick_value(), $urandom());
        if ((it.operation == OP_FORWARD || it.operation == OP_UPDATE) && !loaded[it.index])
          it.operation = OP_LOAD;
        send(it);
        sent++;
      end
    end
  endtask

  initial begin
    drow_t rows [$];
    drow_t r;
    in_item_t it;
    for (int i = 0; i < 256; i++) begin
      weights[i] = 0;
      deltas[i] = 0;
      loaded[i] = 1'b0;
    end
    acc_sum = 0;
    neuron_out = 0;
    neuron_grad = 0;
    errors = 0;
    cycles = 0;
    idle_mode = 0;
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    out_bus.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: output is zero after reset, so the slope is one
    mk(r.item, OP_OUT_GRD, 0, 16'sd4096, 0, 0); r.typed = 1;
    r.want = '{KIND_GRAD, 16'sd4096, 8'd0}; rows = {rows, r};
    mk(r.item, OP_OUT_GRD, 8'hff, 16'h8000, 16'hffff, 1); r.typed = 1;
    r.want = '{KIND_GRAD, -16'sd32768, 8'd0}; rows = {rows, r};
    r.typed = 0;
    mk(r.item, OP_LOAD, 0, 16'h7fff, 0, 0); rows = {rows, r};
    mk(r.item, OP_LOAD, 8'hff, 16'h8000, 0, 1); rows = {rows, r};
    mk(r.item, OP_FORWARD, 0, 16'h7fff, 0, 0); rows = {rows, r};
    // huge sum saturates tanh to one
    mk(r.item, OP_FORWARD, 8'hff, 16'h8000, 0, 1); r.typed = 1;
    r.want = '{KIND_OUTPUT, 16'sd4096, 8'd0}; rows = {rows, r};
    // zero slope at full output
    mk(r.item, OP_OUT_GRD, 0, 16'h8000, 0, 0); r.want = '{KIND_GRAD, 16'sd0, 8'd0};
    rows = {rows, r};
    r.typed = 0;
    mk(r.item, OP_HID_GRD, 0, 16'h7fff, 16'h7fff, 0); rows = {rows, r};
    mk(r.item, OP_HID_GRD, 3, 16'hffff, 16'h0005, 1); rows = {rows, r};
    mk(r.item, OP_UPDATE, 0, 16'h7fff, 0, 0); rows = {rows, r};
    mk(r.item, OP_UPDATE, 8'hff, 16'h8000, 0, 0); rows = {rows, r};
    mk(r.item, 3'd5, 0, 16'h1234, 16'h4321, 1); rows = {rows, r};
    mk(r.item, 3'd6, 8'h55, 16'h8000, 16'h7fff, 0); rows = {rows, r};
    mk(r.item, 3'd7, 8'haa, 16'h7fff, 16'h8000, 1); rows = {rows, r};
    mk(r.item, OP_FORWARD, 0, 0, 0, 1); r.typed = 1;
    r.want = '{KIND_OUTPUT, 16'sd0, 8'd0}; rows = {rows, r};
    // a hidden run of only its last element sums nothing, so no gradient
    mk(r.item, OP_HID_GRD, 0, 16'h7fff, 16'h7fff, 1); r.want = '{KIND_GRAD, 16'sd0, 8'd0};
    rows = {rows, r};
    r.typed = 0;
    mk(r.item, OP_LOAD, 8'h80, 0, 0, 0); rows = {rows, r};
    mk(r.item, OP_FORWARD, 8'h80, 16'hffff, 0, 1); rows = {rows, r};
    mk(r.item, OP_LOAD, 8'h01, 16'h1000, 0, 0); rows = {rows, r};
    mk(r.item, OP_FORWARD, 8'h01, 16'h2000, 0, 1); rows = {rows, r};
    mk(r.item, OP_OUT_GRD, 0, 16'h0800, 0, 0); rows = {rows, r};
    mk(r.item, OP_UPDATE, 8'h01, 16'h2000, 0, 0); rows = {rows, r};
    mk(r.item, OP_UPDATE, 8'h01, 16'h2000, 0, 0); rows = {rows, r};
    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_LEARNING_RATE, 16'hffff);
          write_reg(CFG_MOMENTUM, 16'hffff);
        end
        2: begin
          write_reg(CFG_LEARNING_RATE, 16'h0000);
          write_reg(CFG_MOMENTUM, 16'h0000);
        end
        3: begin
          write_reg(CFG_LEARNING_RATE, $urandom());
          write_reg(CFG_MOMENTUM, $urandom());
        end
        default: ;
      endcase
      idle_mode = ph;
      random_phase();
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/nbu_pkg.sv
rtl/core/nbu_in_if.sv
rtl/core/nbu_out_if.sv
rtl/core/nbu_store.sv
rtl/core/neuron_backprop_unit_core.sv
tb/tb_top.sv
